FILE: hdl/crsc_pkg.sv
// Shared types and constants for the clock replacement slot cache.
// Depends on nothing; imported by every module of the block.
package crsc_pkg;

    localparam int KEY_W  = 14;    // request key width
    localparam int CFG_W  = 10;    // active slot count register width
    localparam int IDX_W  = 9;     // reported slot index width
    localparam int WORD_W = KEY_W + 2;

    // Tag store word layout: {valid, reference, tag}
    localparam int VLD_BIT = WORD_W - 1;
    localparam int REF_BIT = WORD_W - 2;

    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 10'd512;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_SWEEP_RD,
        ST_SWEEP_CHK
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture key and slot count, rewind scan pointer
        logic clr_wr;      // clearing pass: write empty word, step pointer
        logic rd_look;     // read the entry under the scan pointer
        logic look_next;   // step the scan pointer
        logic sweep_init;  // bring the hand back in range
        logic rd_sweep;    // read the entry under the hand
        logic sweep_pass;  // clear reference bit under the hand, step hand
        logic wr_hit;      // set reference bit at scan pointer, load hit result
        logic wr_victim;   // install key under the hand, load miss result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic match;       // entry read is valid and holds the key
        logic last;        // scan pointer is on the last active slot
        logic evict;       // entry read is empty or unreferenced
        logic clr_last;    // clearing pass is on the final entry
    } t_sts;

endpackage

FILE: hdl/crsc_ctrl.sv
// Controller state machine for the clock replacement slot cache.
// Depends on crsc_pkg; drives crsc_dp through t_cmd and reads t_sts.
module crsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  crsc_pkg::t_sts i_sts,
    output crsc_pkg::t_cmd o_cmd
);
    import crsc_pkg::*;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   out_free;
    logic   finish;

    // State and response valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign out_free = !r_rsp_valid || i_rsp_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        finish      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK_RD;
                end
            end
            ST_LOOK_RD: begin
                o_cmd.rd_look = 1'b1;
                n_state       = ST_LOOK_CHK;
            end
            ST_LOOK_CHK: begin
                if (i_sts.match) begin
                    // hold here until the result register is free
                    if (out_free) begin
                        o_cmd.wr_hit = 1'b1;
                        finish       = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else if (i_sts.last) begin
                    o_cmd.sweep_init = 1'b1;
                    n_state          = ST_SWEEP_RD;
                end else begin
                    o_cmd.look_next = 1'b1;
                    n_state         = ST_LOOK_RD;
                end
            end
            ST_SWEEP_RD: begin
                o_cmd.rd_sweep = 1'b1;
                n_state        = ST_SWEEP_CHK;
            end
            ST_SWEEP_CHK: begin
                if (i_sts.evict) begin
                    if (out_free) begin
                        o_cmd.wr_victim = 1'b1;
                        finish          = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    // second chance: clear the bit and move on
                    o_cmd.sweep_pass = 1'b1;
                    n_state          = ST_SWEEP_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        if (finish) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

FILE: hdl/crsc_dp.sv
// Datapath for the clock replacement slot cache: tag store memory, scan
// pointer, clock hand, slot count register and result register. Depends on crsc_pkg.
module crsc_dp #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crsc_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [crsc_pkg::KEY_W-1:0]  i_request_key,
    input  crsc_pkg::t_cmd              i_cmd,
    output crsc_pkg::t_sts              o_sts,
    output logic                        o_hit,
    output logic [crsc_pkg::IDX_W-1:0]  o_slot_index
);
    import crsc_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int NW = SW + 1;
    localparam int EW = (NW > CFG_W) ? NW : CFG_W;
    localparam logic [EW-1:0] MAX_E    = EW'(MAX_SLOTS);
    localparam logic [SW-1:0] LAST_MEM = SW'(MAX_SLOTS - 1);

    logic [CFG_W-1:0]  r_active_slots;
    logic [KEY_W-1:0]  r_key;
    logic [SW-1:0]     r_last_idx;
    logic [SW-1:0]     r_ptr;
    logic [SW-1:0]     r_hand;
    logic [WORD_W-1:0] r_mem [MAX_SLOTS];
    logic [WORD_W-1:0] r_rdata;
    logic              r_hit;
    logic [SW-1:0]     r_slot;

    logic [EW-1:0]     cfg_ext;
    logic [EW-1:0]     n_eff;
    logic [SW-1:0]     n_last_idx;
    logic [SW-1:0]     hand_step;
    logic [SW-1:0]     mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [WORD_W-1:0] mem_wdata;

    // Effective slot count: zero acts as one, clamp at MAX_SLOTS
    assign cfg_ext = EW'(r_active_slots);
    always_comb begin
        if (cfg_ext == '0) begin
            n_eff = EW'(1);
        end else if (cfg_ext > MAX_E) begin
            n_eff = MAX_E;
        end else begin
            n_eff = cfg_ext;
        end
    end
    assign n_last_idx = SW'(n_eff - EW'(1));

    // Hand advance with wrap at the active count
    assign hand_step = (r_hand == r_last_idx) ? '0 : r_hand + 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACTIVE_SLOTS_RST;
        end else if (i_cfg_we) begin
            r_active_slots <= i_cfg_wdata;
        end
    end

    // Scan pointer and clock hand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_hand <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.look_next) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.sweep_init) begin
                if (r_hand > r_last_idx) begin
                    r_hand <= '0;
                end
            end else if (i_cmd.sweep_pass || i_cmd.wr_victim) begin
                r_hand <= hand_step;
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key      <= i_request_key;
            r_last_idx <= n_last_idx;
        end
    end

    // Memory port control
    assign mem_addr = (i_cmd.rd_sweep || i_cmd.sweep_pass || i_cmd.wr_victim) ? r_hand : r_ptr;
    assign mem_re   = i_cmd.rd_look || i_cmd.rd_sweep;
    assign mem_we   = i_cmd.clr_wr || i_cmd.wr_hit || i_cmd.sweep_pass || i_cmd.wr_victim;

    always_comb begin
        if (i_cmd.wr_victim) begin
            mem_wdata = {1'b1, 1'b1, r_key};
        end else if (i_cmd.wr_hit) begin
            mem_wdata = {1'b1, 1'b1, r_rdata[KEY_W-1:0]};
        end else if (i_cmd.sweep_pass) begin
            mem_wdata = {1'b1, 1'b0, r_rdata[KEY_W-1:0]};
        end else begin
            mem_wdata = '0;
        end
    end

    // Tag store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // Status back to the controller
    assign o_sts.match    = r_rdata[VLD_BIT] && (r_rdata[KEY_W-1:0] == r_key);
    assign o_sts.last     = (r_ptr == r_last_idx);
    assign o_sts.evict    = !r_rdata[VLD_BIT] || !r_rdata[REF_BIT];
    assign o_sts.clr_last = (r_ptr == LAST_MEM);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hit) begin
            r_hit  <= 1'b1;
            r_slot <= r_ptr;
        end else if (i_cmd.wr_victim) begin
            r_hit  <= 1'b0;
            r_slot <= r_hand;
        end
    end

    assign o_hit        = r_hit;
    assign o_slot_index = IDX_W'(r_slot);

endmodule

FILE: hdl/clock_replacement_slot_cache_top.sv
// Top level of the clock replacement slot cache.
// Depends on crsc_pkg, crsc_ctrl and crsc_dp.
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_request_key
//  response  out        o_rsp_valid / i_rsp_ready    o_hit, o_slot_index
//  config    in         i_cfg_we                     i_cfg_wdata
//
// One tag store memory with a registered read port; each slot visited takes a read,
// then a check and write back. A hit on slot i ends the lookup at that slot; a miss
// reads all n active slots and then sweeps the hand, at most n+1 steps, where n is the
// active slot count. After reset a clearing pass writes all MAX_SLOTS entries empty
// and no request is taken. A stalled response holds the block in its final check until
// the result register frees; a new request is taken once idle.
module clock_replacement_slot_cache_top #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crsc_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [crsc_pkg::KEY_W-1:0]  i_request_key,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic                        o_hit,
    output logic [crsc_pkg::IDX_W-1:0]  o_slot_index
);
    import crsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    crsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Tag store and clock hand
    crsc_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_request_key (i_request_key),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_hit         (o_hit),
        .o_slot_index  (o_slot_index)
    );

endmodule

FILE: hdl/crsc_checker.sv
// Port level checks for the clock replacement slot cache, bound to the top.
// Depends on crsc_pkg and clock_replacement_slot_cache_top.
module crsc_checker #(
    parameter int MAX_SLOTS = 512
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        o_req_ready,
    input logic                        o_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        o_hit,
    input logic [crsc_pkg::IDX_W-1:0]  o_slot_index
);
    import crsc_pkg::*;

    // Reset starts the clearing pass, so no request is taken next cycle
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("request ready right after reset");

    // An accepted transaction leaves the block busy in the cycle after acceptance
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("ready again directly after accepting a transaction");

    // A new result only appears as a busy block finishes
    a_rsp_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(!o_req_ready))
        else $error("response raised while the block stood idle");

    // Reported slot lies inside the store
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (MAX_SLOTS >= 512) || (int'(o_slot_index) < MAX_SLOTS))
        else $error("slot index beyond the store");

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=>
            o_rsp_valid && $stable(o_hit) && $stable(o_slot_index))
        else $error("stalled response changed");

endmodule

bind clock_replacement_slot_cache_top crsc_checker #(
    .MAX_SLOTS (MAX_SLOTS)
) u_crsc_checker (.*);
